// ===== rtl/inf_pkg.sv =====
// Shared constants, types and the contrast map of the impulse noise filter.
package inf_pkg;

    // Pixel and configuration widths
    localparam int PIX_W      = 8;
    localparam int THR_W      = 8;
    localparam int COLS_CFG_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Default frame limits handed to the top level
    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd2;

    // Register reset values
    localparam int RST_THRESHOLD = 3;
    localparam int RST_COLUMNS   = 77;
    localparam int RST_ROWS      = 20;

    // Input word action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Neighborhood
    localparam int NBR_COUNT  = 8;
    localparam int MEAN_SHIFT = 3;
    localparam int SUM_W      = PIX_W + MEAN_SHIFT;

    // Contrast map breakpoints and levels
    localparam logic [PIX_W-1:0] MAP_ZERO_TOP = 8'd3;
    localparam logic [PIX_W-1:0] MAP_ONE_BOT  = 8'd4;
    localparam logic [PIX_W-1:0] MAP_ONE_TOP  = 8'd6;
    localparam logic [PIX_W-1:0] MAP_FOUR_BOT = 8'd7;
    localparam logic [PIX_W-1:0] MAP_FOUR_TOP = 8'd9;
    localparam logic [PIX_W-1:0] MAP_ONE_VAL  = 8'd1;
    localparam logic [PIX_W-1:0] MAP_FOUR_VAL = 8'd4;

    // What an accepted word does to the line buffers
    typedef struct packed {
        logic step;    // word advances the window
        logic wr_mid;  // word carries a pixel to store
    } t_acc;

    // What the window step produces
    typedef struct packed {
        logic emit;      // a result leaves for this step
        logic last;      // result is the frame's final pixel
        logic interior;  // emitted pixel has all 8 neighbors
    } t_step;

    function automatic logic [PIX_W-1:0] contrast_map(input logic [PIX_W-1:0] v);
        logic [PIX_W-1:0] m;
        if (v inside {[8'd0 : MAP_ZERO_TOP]}) begin
            m = '0;
        end else if (v inside {[MAP_ONE_BOT : MAP_ONE_TOP]}) begin
            m = MAP_ONE_VAL;
        end else if (v inside {[MAP_FOUR_BOT : MAP_FOUR_TOP]}) begin
            m = MAP_FOUR_VAL;
        end else begin
            m = v;
        end
        return m;
    endfunction

endpackage

// ===== rtl/inf_in_if.sv =====
// Input channel: one word carries an action and a raw pixel.
interface inf_in_if;
    import inf_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

// ===== rtl/inf_out_if.sv =====
// Output channel: one word carries a mapped pixel and the end-of-frame flag.
interface inf_out_if;
    import inf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== rtl/inf_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
module inf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/inf_ctrl.sv =====
// Configuration registers, frame position counters and per-word step decode.
module inf_ctrl #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [inf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [inf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_fire,
    input  logic                            i_action,
    output inf_pkg::t_acc                   o_acc,
    output logic [$clog2(MAX_COLUMNS)-1:0]  o_col,
    output inf_pkg::t_step                  o_step,
    output logic [$clog2(MAX_COLUMNS)-1:0]  o_qcol,
    output logic [inf_pkg::THR_W-1:0]       o_thr,
    output logic                            o_rows_one
);
    import inf_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int RST_COLS_C = (RST_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RST_COLUMNS;
    localparam int RST_ROWS_C = (RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS;

    logic [THR_W-1:0]  r_thr,  n_thr;
    logic [COLS_W-1:0] r_cols, n_cols;
    logic [ROWS_W-1:0] r_rows, n_rows;
    logic [COL_W-1:0]  r_col,  n_col;   // column of the next window step
    logic [ROW_W-1:0]  r_row,  n_row;   // row of the next stored pixel
    logic              r_full, n_full;
    logic [COL_W-1:0]  r_qcol, n_qcol;  // position of the next pixel to emit
    logic [ROW_W-1:0]  r_qrow, n_qrow;

    logic [COLS_CFG_W-1:0] w_cols_raw;
    logic [COLS_W-1:0]     w_cols_clamped;
    logic [ROWS_W-1:0]     w_rows_clamped;
    logic                  w_take_pix;
    logic                  w_take_drain;
    logic                  w_step;
    logic                  w_emit;
    logic                  w_last;
    logic                  w_interior;
    logic                  w_col_end;
    logic                  w_row_end;
    logic                  w_qcol_end;

    // Clamp frame sizes into 1..MAX
    assign w_cols_raw = i_cfg_data[COLS_CFG_W-1:0];

    always_comb begin
        if (w_cols_raw == '0) begin
            w_cols_clamped = COLS_W'(1);
        end else if (int'(w_cols_raw) > MAX_COLUMNS) begin
            w_cols_clamped = COLS_W'(MAX_COLUMNS);
        end else begin
            w_cols_clamped = COLS_W'(w_cols_raw);
        end
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            w_rows_clamped = ROWS_W'(1);
        end else if (int'(i_cfg_data) > MAX_ROWS) begin
            w_rows_clamped = ROWS_W'(MAX_ROWS);
        end else begin
            w_rows_clamped = ROWS_W'(i_cfg_data);
        end
    end

    // Pixels are ignored once the frame is full; drains count only then
    assign w_take_pix   = i_fire && (i_action == ACT_PIXEL) && !r_full;
    assign w_take_drain = i_fire && (i_action == ACT_DRAIN) && r_full;
    assign w_step       = w_take_pix || w_take_drain;

    // A pixel emits once one row plus one pixel is stored ahead of it
    assign w_emit = w_take_drain ||
                    (w_take_pix && ((r_row >= ROW_W'(2)) ||
                                    ((r_row == ROW_W'(1)) && (r_col != '0))));

    assign w_col_end  = (COLS_W'(r_col) == r_cols - COLS_W'(1));
    assign w_row_end  = (ROWS_W'(r_row) == r_rows - ROWS_W'(1));
    assign w_qcol_end = (COLS_W'(r_qcol) == r_cols - COLS_W'(1));
    assign w_last     = w_qcol_end && (ROWS_W'(r_qrow) == r_rows - ROWS_W'(1));
    assign w_interior = (r_qrow != '0) && (ROWS_W'(r_qrow) + ROWS_W'(1) < r_rows) &&
                        (r_qcol != '0) && (COLS_W'(r_qcol) + COLS_W'(1) < r_cols);

    always_comb begin
        n_thr  = r_thr;
        n_cols = r_cols;
        n_rows = r_rows;
        n_col  = r_col;
        n_row  = r_row;
        n_full = r_full;
        n_qcol = r_qcol;
        n_qrow = r_qrow;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD: begin
                    n_thr = i_cfg_data[THR_W-1:0];
                end
                REG_COLUMNS: begin
                    // size change abandons the frame
                    n_cols = w_cols_clamped;
                    n_col  = '0;
                    n_row  = '0;
                    n_full = 1'b0;
                    n_qcol = '0;
                    n_qrow = '0;
                end
                REG_ROWS: begin
                    n_rows = w_rows_clamped;
                    n_col  = '0;
                    n_row  = '0;
                    n_full = 1'b0;
                    n_qcol = '0;
                    n_qrow = '0;
                end
                default: begin
                    n_thr = r_thr;
                end
            endcase
        end else begin
            if (w_step) begin
                n_col = w_col_end ? '0 : r_col + COL_W'(1);
            end
            if (w_take_pix && w_col_end) begin
                if (w_row_end) begin
                    n_row  = '0;
                    n_full = 1'b1;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            if (w_emit) begin
                if (w_last) begin
                    // frame done: start over
                    n_col  = '0;
                    n_row  = '0;
                    n_full = 1'b0;
                    n_qcol = '0;
                    n_qrow = '0;
                end else if (w_qcol_end) begin
                    n_qcol = '0;
                    n_qrow = r_qrow + ROW_W'(1);
                end else begin
                    n_qcol = r_qcol + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_W'(RST_THRESHOLD);
            r_cols <= COLS_W'(RST_COLS_C);
            r_rows <= ROWS_W'(RST_ROWS_C);
            r_col  <= '0;
            r_row  <= '0;
            r_full <= 1'b0;
            r_qcol <= '0;
            r_qrow <= '0;
        end else begin
            r_thr  <= n_thr;
            r_cols <= n_cols;
            r_rows <= n_rows;
            r_col  <= n_col;
            r_row  <= n_row;
            r_full <= n_full;
            r_qcol <= n_qcol;
            r_qrow <= n_qrow;
        end
    end

    assign o_acc.step      = w_step;
    assign o_acc.wr_mid    = w_take_pix;
    assign o_col           = r_col;
    assign o_step.emit     = w_emit;
    assign o_step.last     = w_last;
    assign o_step.interior = w_interior;
    assign o_qcol          = r_qcol;
    assign o_thr           = r_thr;
    assign o_rows_one      = (r_rows == ROWS_W'(1));
endmodule

// ===== rtl/inf_filter.sv =====
// Line buffers, 3x3 window registers, outlier test, neighbor mean and contrast map.
module inf_filter #(
    parameter int MAX_COLUMNS = 128
) (
    input  logic                            i_clk,
    input  inf_pkg::t_acc                   i_acc,
    input  logic [$clog2(MAX_COLUMNS)-1:0]  i_addr,
    input  logic [inf_pkg::PIX_W-1:0]       i_pixel,
    input  inf_pkg::t_step                  i_step,
    input  logic [$clog2(MAX_COLUMNS)-1:0]  i_qcol,
    input  logic                            i_move,
    input  logic [inf_pkg::THR_W-1:0]       i_thr,
    input  logic                            i_rows_one,
    output inf_pkg::t_step                  o_step,
    output logic [inf_pkg::PIX_W-1:0]       o_pixel_out,
    output logic                            o_frame_last
);
    import inf_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);

    // Stage word
    t_step            r_s1_step;
    logic [COL_W-1:0] r_s1_qcol;
    logic [PIX_W-1:0] r_s1_pix;

    // Left and center columns of the window (previous center and right)
    logic [PIX_W-1:0] r_win_tl, r_win_ml, r_win_bl;
    logic [PIX_W-1:0] r_win_tc, r_win_mc, r_win_bc;

    logic [PIX_W-1:0] w_rd_top;   // cleaned row two above the new pixel
    logic [PIX_W-1:0] w_rd_mid;   // raw row one above the new pixel
    logic [PIX_W-1:0] w_center;
    logic [PIX_W-1:0] w_nbr [NBR_COUNT];
    logic [NBR_COUNT-1:0] w_hit;
    logic [SUM_W-1:0] w_sum;
    logic [PIX_W-1:0] w_mean;
    logic [PIX_W-1:0] w_clean;
    logic             w_replace;

    always_ff @(posedge i_clk) begin
        if (i_acc.step) begin
            r_s1_step <= i_step;
            r_s1_qcol <= i_qcol;
            r_s1_pix  <= i_pixel;
        end
    end

    // Raw rows: write each stored pixel, read the same column (read-first)
    inf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLUMNS)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (i_acc.wr_mid),
        .i_waddr (i_addr),
        .i_wdata (i_pixel),
        .i_re    (i_acc.step),
        .i_raddr (i_addr),
        .o_rdata (w_rd_mid)
    );

    // Cleaned rows: write back each emitted pixel
    inf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLUMNS)) u_top_ram (
        .i_clk   (i_clk),
        .i_we    (i_move && r_s1_step.emit),
        .i_waddr (r_s1_qcol),
        .i_wdata (w_clean),
        .i_re    (i_acc.step),
        .i_raddr (i_addr),
        .o_rdata (w_rd_top)
    );

    // Single-row frames never build a window; take the stored pixel directly
    assign w_center = i_rows_one ? w_rd_mid : r_win_mc;

    always_comb begin
        w_nbr[0] = r_win_tl;
        w_nbr[1] = r_win_tc;
        w_nbr[2] = w_rd_top;
        w_nbr[3] = r_win_ml;
        w_nbr[4] = w_rd_mid;
        w_nbr[5] = r_win_bl;
        w_nbr[6] = r_win_bc;
        w_nbr[7] = r_s1_pix;
    end

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NBR_COUNT; i++) begin
            if (w_center > w_nbr[i]) begin
                w_hit[i] = (w_center - w_nbr[i]) >= i_thr;
            end else begin
                w_hit[i] = (w_nbr[i] - w_center) >= i_thr;
            end
            w_sum = w_sum + SUM_W'(w_nbr[i]);
        end
    end

    assign w_mean    = w_sum[SUM_W-1:MEAN_SHIFT];
    assign w_replace = r_s1_step.emit && r_s1_step.interior && (&w_hit);
    assign w_clean   = w_replace ? w_mean : w_center;

    // Shift the window one column; the cleaned center becomes the left neighbor
    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_win_tl <= r_win_tc;
            r_win_ml <= w_clean;
            r_win_bl <= r_win_bc;
            r_win_tc <= w_rd_top;
            r_win_mc <= w_rd_mid;
            r_win_bc <= r_s1_pix;
        end
    end

    assign o_step       = r_s1_step;
    assign o_pixel_out  = contrast_map(w_clean);
    assign o_frame_last = r_s1_step.last;
endmodule

// ===== rtl/impulse_noise_filter_contrast_top.sv =====
// Top level of the streaming 3x3 impulse noise filter with contrast map.
//
//  channel   dir  handshake          word contents
//  i_pix     in   valid / ready      action (pixel or drain), pixel_in
//  o_pix     out  valid / ready      pixel_out, frame_last
//  i_cfg_*   in   write enable only  register index, data (threshold, columns, rows)
//
// One word is accepted per cycle while the output is not stalled; the word that
// causes a result is held in the window stage, the result in the output register.
// Both line buffers are read on each window step; the raw one stores pixels, the
// cleaned one emitted results. Results trail pixels by one row plus one pixel;
// drain words flush the tail. Synchronous reset clears control only; line buffers
// start undefined and need no clearing pass, every interior read hits a pixel of
// the current frame. A stalled result holds the window stage; i_pix.ready stays
// high while the output register is empty.
module impulse_noise_filter_contrast_top #(
    parameter int MAX_COLUMNS = inf_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = inf_pkg::DEF_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [inf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [inf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    inf_in_if.sink                          i_pix,
    inf_out_if.source                       o_pix
);
    import inf_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);

    t_acc             w_acc;
    t_step            w_step;
    t_step            w_s1_step;
    logic [COL_W-1:0] w_col;
    logic [COL_W-1:0] w_qcol;
    logic [THR_W-1:0] w_thr;
    logic             w_rows_one;
    logic [PIX_W-1:0] w_pix_out;
    logic             w_last;
    logic             w_fire;
    logic             w_s1_move;

    logic             r_s1_valid, n_s1_valid;
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;

    // Window stage moves when it has no result or the output register frees up
    assign w_s1_move = r_s1_valid &&
                       (!w_s1_step.emit || !r_out_valid || o_pix.ready);
    assign i_pix.ready = !r_s1_valid || w_s1_move;
    assign w_fire      = i_pix.valid && i_pix.ready;

    inf_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_action   (i_pix.action),
        .o_acc      (w_acc),
        .o_col      (w_col),
        .o_step     (w_step),
        .o_qcol     (w_qcol),
        .o_thr      (w_thr),
        .o_rows_one (w_rows_one)
    );

    inf_filter #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_filter (
        .i_clk        (i_clk),
        .i_acc        (w_acc),
        .i_addr       (w_col),
        .i_pixel      (i_pix.pixel_in),
        .i_step       (w_step),
        .i_qcol       (w_qcol),
        .i_move       (w_s1_move),
        .i_thr        (w_thr),
        .i_rows_one   (w_rows_one),
        .o_step       (w_s1_step),
        .o_pixel_out  (w_pix_out),
        .o_frame_last (w_last)
    );

    always_comb begin
        // Hold the stage word until it moves; load on a word that steps
        n_s1_valid = r_s1_valid;
        if (w_fire && w_acc.step) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_s1_move && w_s1_step.emit) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move && w_s1_step.emit) begin
            r_out_pix  <= w_pix_out;
            r_out_last <= w_last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_out  = r_out_pix;
    assign o_pix.frame_last = r_out_last;
endmodule

// ===== rtl/inf_checker.sv =====
// Port-level checks of the filter top, attached by bind.
module inf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [inf_pkg::PIX_W-1:0] i_out_pixel,
    input logic                      i_out_last
);
    import inf_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // With no result waiting the block must take input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output register empty");

    // A stalled result holds its word
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_pixel) && $stable(i_out_last)))
        else $error("stalled output word changed or dropped");

    // An input word is refused only while an output word is pending
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |-> i_out_valid)
        else $error("input refused without a pending output word");
endmodule

bind impulse_noise_filter_contrast_top inf_checker u_inf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out),
    .i_out_last  (o_pix.frame_last)
);
